/* sv/khs_pkg.sv */
// Shared types, constants and helper functions for the keyed triple SHA-1 hash.
package khs_pkg;

	typedef logic [31:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} sha_state_t;

	typedef word_t [15:0] wwin_t;

	typedef struct packed {
		logic [127:0] key;
		logic [63:0]  plain;
		logic [4:0]   len;
		logic [159:0] kd;
	} side_t;

	localparam int ROUNDS = 80;
	localparam int MSG_BYTES = 55;

	localparam logic [63:0] KEY_UPPER_RST = 64'h77214d4b196a87cd;
	localparam logic [63:0] KEY_LOWER_RST = 64'h520045fd20a51d67;

	localparam word_t H0 = 32'h67452301;
	localparam word_t H1 = 32'hefcdab89;
	localparam word_t H2 = 32'h98badcfe;
	localparam word_t H3 = 32'h10325476;
	localparam word_t H4 = 32'hc3d2e1f0;

	localparam word_t K0 = 32'h5a827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	localparam logic [0:0] REG_KEY_UPPER = 1'b0;
	localparam logic [0:0] REG_KEY_LOWER = 1'b1;

	function automatic word_t rotl(input word_t x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic word_t round_f(input logic [1:0] grp, input word_t b, input word_t c,
		input word_t d);
		word_t f;
		case (grp)
			2'd0: f = (b & c) | (~b & d);
			2'd2: f = (b & c) | (b & d) | (c & d);
			default: f = b ^ c ^ d;
		endcase
		return f;
	endfunction

	function automatic word_t round_k(input logic [1:0] grp);
		word_t k;
		case (grp)
			2'd0: k = K0;
			2'd1: k = K1;
			2'd2: k = K2;
			default: k = K3;
		endcase
		return k;
	endfunction

	// Pads a message of up to 55 bytes into one block and splits it into words.
	function automatic wwin_t pad_block(input logic [0:MSG_BYTES-1][7:0] msg,
		input logic [5:0] len);
		logic [0:63][7:0] blk;
		logic [15:0] bits;
		logic [511:0] flat;
		wwin_t w;
		bits = {7'd0, len, 3'd0};
		for (int j = 0; j < 64; j++) begin
			if (j < MSG_BYTES && 6'(j) < len) begin
				blk[j] = msg[j];
			end else if (6'(j) == len) begin
				blk[j] = 8'h80;
			end else begin
				blk[j] = 8'h00;
			end
		end
		blk[62] = bits[15:8];
		blk[63] = bits[7:0];
		flat = blk;
		for (int i = 0; i < 16; i++) begin
			w[i] = flat[511 - 32 * i -: 32];
		end
		return w;
	endfunction

endpackage

/* sv/khs_round.sv */
// One registered SHA-1 round with its message schedule window.
module khs_round
	import khs_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       v_i,
	input  sha_state_t st_i,
	input  wwin_t      w_i,
	input  side_t      sd_i,
	output logic       v_o,
	output sha_state_t st_o,
	output wwin_t      w_o,
	output side_t      sd_o
);

	localparam logic [1:0] GRP = 2'(IDX / 20);

	word_t      t;
	word_t      wn;
	sha_state_t st_d;
	wwin_t      w_d;
	logic       v_s1;
	sha_state_t st_s1;
	wwin_t      w_s1;
	side_t      sd_s1;

	always_comb begin
		t = rotl(st_i.a, 5) + round_f(GRP, st_i.b, st_i.c, st_i.d) + st_i.e + round_k(GRP)
			+ w_i[0];
		st_d.a = t;
		st_d.b = st_i.a;
		st_d.c = rotl(st_i.b, 30);
		st_d.d = st_i.c;
		st_d.e = st_i.d;
		wn = rotl(w_i[13] ^ w_i[8] ^ w_i[2] ^ w_i[0], 1);
		for (int i = 0; i < 15; i++) begin
			w_d[i] = w_i[i + 1];
		end
		w_d[15] = wn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= st_d;
			w_s1  <= w_d;
			sd_s1 <= sd_i;
		end
	end

	assign v_o  = v_s1;
	assign st_o = st_s1;
	assign w_o  = w_s1;
	assign sd_o = sd_s1;

endmodule

/* sv/khs_run.sv */
// One full SHA-1 block run: eighty round stages and the final chaining add.
module khs_run
	import khs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_i,
	input  wwin_t        blk_i,
	input  side_t        sd_i,
	output logic         v_o,
	output logic [159:0] dig_o,
	output side_t        sd_o
);

	logic       v   [0:ROUNDS];
	sha_state_t st  [0:ROUNDS];
	wwin_t      w   [0:ROUNDS];
	side_t      sd  [0:ROUNDS];
	logic         v_s1;
	logic [159:0] dig_s1;
	side_t        sd_s1;

	assign v[0]  = v_i;
	assign st[0] = '{a: H0, b: H1, c: H2, d: H3, e: H4};
	assign w[0]  = blk_i;
	assign sd[0] = sd_i;

	for (genvar i = 0; i < ROUNDS; i++) begin : g_rnd
		khs_round #(.IDX(i)) u_rnd (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_i(v[i]), .st_i(st[i]), .w_i(w[i]), .sd_i(sd[i]),
			.v_o(v[i+1]), .st_o(st[i+1]), .w_o(w[i+1]), .sd_o(sd[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v[ROUNDS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dig_s1 <= {st[ROUNDS].a + H0, st[ROUNDS].b + H1, st[ROUNDS].c + H2,
				st[ROUNDS].d + H3, st[ROUNDS].e + H4};
			sd_s1  <= sd[ROUNDS];
		end
	end

	assign v_o   = v_s1;
	assign dig_o = dig_s1;
	assign sd_o  = sd_s1;

endmodule

/* sv/keyed_triple_sha1_hash.sv */
// Top level of the keyed triple SHA-1 hash: key registers, block formatting and three runs.
// The input channel takes a plaintext of up to eight bytes and its length; each transfer
// produces exactly one 160-bit digest on the output channel, in order.
// The configuration channel writes the two halves of the 128-bit key; it is always ready,
// and the key should only change while no item is in flight.
// The datapath is three chained SHA-1 runs, each eighty one-round stages plus a
// chaining add stage.
// One item can enter every cycle while the output is not stalled, giving one digest per cycle.
// The whole pipeline advances together.  When a digest waits at the output and the
// receiver holds ready low, every stage holds and input ready drops in the same cycle;
// nothing is lost or repeated.
// Reset clears all stage valid bits and loads the default key; no clearing pass is needed.
module keyed_triple_sha1_hash
	import khs_pkg::*;
#(
	parameter int MAX_PLAIN_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] plain_bytes,
	input  logic [3:0]  plain_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_top,
	output logic [63:0] digest_middle,
	output logic [31:0] digest_bottom,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0]  key_upper_q;
	logic [63:0]  key_lower_q;
	logic         en;
	logic [4:0]   len;
	side_t        sd0;
	wwin_t        blk1, blk2, blk3;
	logic         v1, v2, v3;
	logic [159:0] d1, d2, d3;
	side_t        s1, s2, s3;
	side_t        s1k;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= KEY_UPPER_RST;
			key_lower_q <= KEY_LOWER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_UPPER: key_upper_q <= cfg_data;
				REG_KEY_LOWER: key_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_comb begin
		len = ({1'b0, plain_length} > 5'(MAX_PLAIN_BYTES)) ? 5'(MAX_PLAIN_BYTES)
			: {1'b0, plain_length};
		sd0.key   = {key_upper_q, key_lower_q};
		sd0.plain = plain_bytes;
		sd0.len   = len;
		sd0.kd    = '0;
		blk1 = pad_block({sd0.key, plain_bytes, 248'd0}, 6'd16 + {1'b0, len});
	end

	khs_run u_run1 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(in_valid && in_ready), .blk_i(blk1),
		.sd_i(sd0), .v_o(v1), .dig_o(d1), .sd_o(s1)
	);

	always_comb begin
		s1k    = s1;
		s1k.kd = d1;
		blk2 = pad_block({s1.key, d1, s1.plain, 88'd0}, 6'd36 + {1'b0, s1.len});
	end

	khs_run u_run2 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v1), .blk_i(blk2),
		.sd_i(s1k), .v_o(v2), .dig_o(d2), .sd_o(s2)
	);

	assign blk3 = pad_block({s2.kd[159:32], d2[159:32], 184'd0}, 6'd32);

	khs_run u_run3 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v2), .blk_i(blk3),
		.sd_i(s2), .v_o(v3), .dig_o(d3), .sd_o(s3)
	);

	assign out_valid     = v3;
	assign digest_top    = d3[159:96];
	assign digest_middle = d3[95:32];
	assign digest_bottom = d3[31:0];

	a_hold_run1: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v1) && $stable(d1))
		else $error("run one output moved during a stall");

	a_hold_run2: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v2) && $stable(s2.kd))
		else $error("run two output moved during a stall");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!v3 || out_ready))
		else $error("input ready does not follow output stall");

endmodule

/* test/tb_top.sv */
// Testbench for the keyed triple SHA-1 hash: randomized transfers checked against a digest predictor.
module tb_top;
	import khs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] plain_bytes;
	logic [3:0]  plain_length;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] digest_top;
	logic [63:0] digest_middle;
	logic [31:0] digest_bottom;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [63:0] cfg_data;

	logic [63:0]  key_hi;
	logic [63:0]  key_lo;
	logic [159:0] pending_digests[$];
	int           errors = 0;
	int           burst_left;
	int           idle_cycles = 0;

	keyed_triple_sha1_hash dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.plain_bytes(plain_bytes), .plain_length(plain_length),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_top(digest_top), .digest_middle(digest_middle),
		.digest_bottom(digest_bottom),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [159:0] sha1_one_block(input logic [7:0] msg[0:63], input int len);
		logic [7:0]  blk[0:63];
		logic [31:0] w[0:79];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		logic [15:0] bits;
		for (int i = 0; i < 64; i++) begin
			blk[i] = (i < len) ? msg[i] : 8'h00;
		end
		blk[len] = 8'h80;
		bits = 16'(len * 8);
		blk[62] = bits[15:8];
		blk[63] = bits[7:0];
		for (int i = 0; i < 16; i++) begin
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		end
		for (int i = 16; i < 80; i++) begin
			x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {x[30:0], x[31]};
		end
		a = 32'h67452301;
		b = 32'hefcdab89;
		c = 32'h98badcfe;
		d = 32'h10325476;
		e = 32'hc3d2e1f0;
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5a827999;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ed9eba1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8f1bbcdc;
			end else begin
				f = b ^ c ^ d;
				k = 32'hca62c1d6;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		return {a + 32'h67452301, b + 32'hefcdab89, c + 32'h98badcfe,
			d + 32'h10325476, e + 32'hc3d2e1f0};
	endfunction

	function automatic logic [159:0] keyed_digest(input logic [127:0] key,
		input logic [63:0] plain, input logic [3:0] len_in);
		logic [7:0]   msg[0:63];
		logic [159:0] kd, vd;
		int           len;
		len = (len_in > 8) ? 8 : int'(len_in);
		for (int i = 0; i < 64; i++) msg[i] = 8'h00;
		for (int i = 0; i < 16; i++) msg[i] = key[127-8*i -: 8];
		for (int i = 0; i < len; i++) msg[16+i] = plain[63-8*i -: 8];
		kd = sha1_one_block(msg, 16 + len);
		for (int i = 0; i < 20; i++) msg[16+i] = kd[159-8*i -: 8];
		for (int i = 0; i < len; i++) msg[36+i] = plain[63-8*i -: 8];
		vd = sha1_one_block(msg, 36 + len);
		for (int i = 0; i < 16; i++) begin
			msg[i] = kd[159-8*i -: 8];
			msg[16+i] = vd[159-8*i -: 8];
		end
		return sha1_one_block(msg, 32);
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	always @(posedge clk) begin
		logic [159:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_digests.size() == 0) begin
				report_mismatch("digest with no transfer pending");
			end else begin
				want = pending_digests.pop_front();
				if (digest_top !== want[159:96])
					report_mismatch($sformatf("digest_top %h, want %h", digest_top,
						want[159:96]));
				if (digest_middle !== want[95:32])
					report_mismatch($sformatf("digest_middle %h, want %h", digest_middle,
						want[95:32]));
				if (digest_bottom !== want[31:0])
					report_mismatch($sformatf("digest_bottom %h, want %h", digest_bottom,
						want[31:0]));
			end
		end
	end

	// The receiver switches between always ready, random stalls and long stalls.
	always @(posedge clk) begin
		int cyc;
		int mode;
		cyc++;
		if (cyc % 300 == 0) mode = $urandom_range(0, 2);
		case (mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				out_ready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic send_plaintext(input logic [63:0] data, input logic [3:0] len);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		plain_bytes <= data;
		plain_length <= len;
		do @(posedge clk); while (!in_ready);
		pending_digests = {pending_digests, keyed_digest({key_hi, key_lo}, data, len)};
		burst_left--;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		wait (pending_digests.size() == 0);
		repeat (260) @(posedge clk);
	endtask

	task automatic write_key(input logic [63:0] upper, input logic [63:0] lower);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= REG_KEY_UPPER;
		cfg_data <= upper;
		do @(posedge clk); while (!cfg_ready);
		key_hi = upper;
		cfg_index <= REG_KEY_LOWER;
		cfg_data <= lower;
		do @(posedge clk); while (!cfg_ready);
		key_lo = lower;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_lengths_and_extremes();
		for (int n = 0; n <= 8; n++) send_plaintext({$urandom, $urandom}, 4'(n));
		send_plaintext(64'h0, 4'd8);
		send_plaintext(64'hffff_ffff_ffff_ffff, 4'd8);
		send_plaintext(64'hffff_ffff_ffff_ffff, 4'd0);
		send_plaintext(64'h0123_4567_89ab_cdef, 4'd3);
		for (int n = 9; n <= 15; n++) send_plaintext({$urandom, $urandom}, 4'(n));
	endtask

	task automatic test_key_extremes();
		write_key(64'h0, 64'h0);
		send_plaintext(64'hffff_ffff_ffff_ffff, 4'd8);
		send_plaintext(64'h0, 4'd0);
		write_key(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
		send_plaintext(64'h0, 4'd8);
		send_plaintext(64'h8000_0000_0000_0001, 4'd15);
	endtask

	task automatic test_random_plaintext();
		logic [3:0] len;
		for (int i = 0; i < 1000; i++) begin
			if (i % 250 == 0) write_key({$urandom, $urandom}, {$urandom, $urandom});
			len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			send_plaintext({$urandom, $urandom}, len);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		plain_bytes = 64'h0;
		plain_length = 4'h0;
		cfg_valid = 1'b0;
		cfg_index = REG_KEY_UPPER;
		cfg_data = 64'h0;
		key_hi = KEY_UPPER_RST;
		key_lo = KEY_LOWER_RST;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_lengths_and_extremes();
		test_key_extremes();
		test_random_plaintext();
		wait_drained();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

/* keyed_triple_sha1_hash.f */
sv/khs_pkg.sv
sv/khs_round.sv
sv/khs_run.sv
sv/keyed_triple_sha1_hash.sv
test/tb_top.sv
